// ===== hdl/tcw_pkg.sv =====
// Shared constants and types for the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS  = 120;
    localparam int ROWS     = 40;
    localparam int CELLS    = ROWS * COLUMNS;

    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(COLUMNS + 1);

    localparam logic [7:0]  CH_NEWLINE = 8'd10;
    localparam logic [7:0]  CH_RETURN  = 8'd13;
    localparam logic [7:0]  CH_SPACE   = 8'd32;
    localparam logic [23:0] WHITE      = 24'hFFFFFF;
    localparam logic [23:0] BLACK      = 24'h000000;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic REG_TEXT_COLOUR = 1'b0;
    localparam logic REG_BACK_COLOUR = 1'b1;

    typedef struct packed {
        logic [7:0]  ch;
        logic [23:0] fore;
        logic [23:0] back;
    } t_cell;

    typedef struct packed {
        logic [6:0]  col;
        logic [5:0]  row;
        logic        scrolled;
        logic [7:0]  ch;
        logic [23:0] fore;
        logic [23:0] back;
    } t_result;

endpackage

// ===== hdl/text_console_char_writer_top.sv =====
// Text console: cursor handling, character writes, scrolling and cell reads.
`timescale 1ns / 1ps
//
// Requests arrive on the input channel (i_in_valid / o_in_stall); each request
// yields exactly one result on the output channel (o_out_valid / i_out_stall).
// A put request with an ordinary byte writes one cell at the cursor; newline and
// carriage return write no cell, but a newline can scroll. A read returns one cell.
// Path from the accepting edge to o_out_valid:
//   put without scroll: the result is registered at the accepting edge, and a
//   new request is taken every cycle while the receiver does not stall;
//   read: through the registered read port of the cell memory, then the output;
//   put that scrolls: one column of the new bottom row written per cycle, through
//   the single memory write port, once the old bottom row's first column is fetched.
// After reset the cell memory is swept to spaces, white on black, one cell per
// cycle, and o_in_stall stays high until the sweep ends. Colour registers
// may be written at any time the block is idle, also during that sweep.
// If the receiver stalls, the result is held in the output register and one
// more finished result can wait in a pending register; the block stops taking
// requests until that pending result has moved to the output.
module text_console_char_writer_top
    import tcw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_char_code,
    input  logic [5:0]  i_read_row,
    input  logic [6:0]  i_read_col,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_cursor_col,
    output logic [5:0]  o_cursor_row,
    output logic        o_scrolled,
    output logic [7:0]  o_cell_char,
    output logic [23:0] o_cell_fore,
    output logic [23:0] o_cell_back
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [COL_W-1:0]   r_cur_x;
    logic [ROW_W-1:0]   r_cur_y;
    logic [ROW_W-1:0]   r_top;
    logic [ADDR_W-1:0]  r_top_base;
    logic [23:0]        r_text;
    logic [23:0]        r_back;
    logic [CNT_W-1:0]   r_sc_cnt;
    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_dst;
    logic               r_oor;
    logic               r_out_valid;
    t_result            r_out;
    t_result            r_pend;

    t_cell              r_mem [CELLS];
    t_cell              r_rd_data;

    logic               acc;
    logic               is_read;
    logic               rd_oor;
    logic [ROW_W-1:0]   au_row;
    logic [COL_W-1:0]   au_col;
    logic [ROW_W:0]     au_sum;
    logic [ROW_W-1:0]   au_srow;
    logic [ADDR_W-1:0]  au_addr;
    logic [COL_W:0]     nx;
    logic [ROW_W:0]     ny;
    logic               wr_char;
    logic               do_scroll;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    t_cell              mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    logic               fin_v;
    t_result            fin;
    logic               out_free;

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_cursor_col = r_out.col;
    assign o_cursor_row = r_out.row;
    assign o_scrolled   = r_out.scrolled;
    assign o_cell_char  = r_out.ch;
    assign o_cell_fore  = r_out.fore;
    assign o_cell_back  = r_out.back;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        acc     = i_in_valid && (r_state == S_IDLE);
        is_read = (i_operation == OP_READ);
        rd_oor  = (int'(i_read_row) >= ROWS) || (int'(i_read_col) >= COLUMNS);

        // Shared address unit: screen row/column to a cell address.
        if (r_state == S_IDLE && is_read) begin
            au_row = ROW_W'(i_read_row);
            au_col = COL_W'(i_read_col);
        end else begin
            au_row = r_cur_y;
            au_col = r_cur_x;
        end
        au_sum = {1'b0, au_row} + {1'b0, r_top};
        if (au_sum >= (ROW_W + 1)'(ROWS)) begin
            au_srow = ROW_W'(au_sum - (ROW_W + 1)'(ROWS));
        end else begin
            au_srow = ROW_W'(au_sum);
        end
        au_addr = ADDR_W'(au_srow) * ADDR_W'(COLUMNS) + ADDR_W'(au_col);

        // Cursor movement of a put request.
        nx      = {1'b0, r_cur_x};
        ny      = {1'b0, r_cur_y};
        wr_char = 1'b0;
        case (i_char_code)
            CH_NEWLINE: begin
                nx = '0;
                ny = ny + 1'b1;
            end
            CH_RETURN: begin
                nx = '0;
            end
            default: begin
                wr_char = 1'b1;
                nx      = nx + 1'b1;
            end
        endcase
        if (nx >= (COL_W + 1)'(COLUMNS)) begin
            nx = '0;
            ny = ny + 1'b1;
        end
        do_scroll = (ny >= (ROW_W + 1)'(ROWS));
        if (do_scroll) begin
            ny = (ROW_W + 1)'(ROWS - 1);
        end

        mem_we    = 1'b0;
        mem_waddr = au_addr;
        mem_wdata = '{ch: i_char_code, fore: r_text, back: r_back};
        fin_v     = 1'b0;
        fin       = '{col: 7'(r_cur_x), row: 6'(r_cur_y), scrolled: 1'b0,
                      ch: 8'd0, fore: BLACK, back: BLACK};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '{ch: CH_SPACE, fore: WHITE, back: BLACK};
            end
            S_IDLE: begin
                mem_we  = acc && !is_read && wr_char;
                fin_v   = acc && !is_read && !do_scroll;
                fin.col = 7'(nx);
                fin.row = 6'(ny);
            end
            S_READ: begin
                fin_v = 1'b1;
                if (!r_oor) begin
                    fin.ch   = r_rd_data.ch;
                    fin.fore = r_rd_data.fore;
                    fin.back = r_rd_data.back;
                end
            end
            S_SCROLL: begin
                // Read of column k overlaps the write of column k-1.
                mem_we       = (r_sc_cnt != '0);
                mem_waddr    = r_dst;
                mem_wdata    = '{ch: CH_SPACE, fore: r_rd_data.fore, back: r_back};
                fin_v        = (r_sc_cnt == CNT_W'(COLUMNS));
                fin.scrolled = 1'b1;
            end
            S_DONE: begin
                fin_v = 1'b0;
            end
            default: begin
                fin_v = 1'b0;
            end
        endcase

        if (r_state == S_SCROLL) begin
            mem_raddr = r_src;
        end else if (rd_oor) begin
            mem_raddr = '0;
        end else begin
            mem_raddr = au_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_top       <= '0;
            r_top_base  <= '0;
            r_text      <= WHITE;
            r_back      <= BLACK;
            r_sc_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_TEXT_COLOUR: r_text <= i_cfg_data;
                    REG_BACK_COLOUR: r_back <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (acc) begin
                        if (is_read) begin
                            r_oor   <= rd_oor;
                            r_state <= S_READ;
                        end else begin
                            r_cur_x <= COL_W'(nx);
                            r_cur_y <= ROW_W'(ny);
                            if (do_scroll) begin
                                r_state  <= S_SCROLL;
                                r_sc_cnt <= '0;
                                r_dst    <= r_top_base;
                                // The old bottom row sits just above the top in the ring.
                                if (r_top == '0) begin
                                    r_src <= ADDR_W'(CELLS - COLUMNS);
                                end else begin
                                    r_src <= r_top_base - ADDR_W'(COLUMNS);
                                end
                            end
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_READ;
                end
                S_SCROLL: begin
                    r_sc_cnt <= r_sc_cnt + 1'b1;
                    if (r_sc_cnt < CNT_W'(COLUMNS)) begin
                        r_src <= r_src + 1'b1;
                    end
                    if (r_sc_cnt != '0) begin
                        r_dst <= r_dst + 1'b1;
                    end
                    if (r_sc_cnt == CNT_W'(COLUMNS)) begin
                        if (r_top == ROW_W'(ROWS - 1)) begin
                            r_top      <= '0;
                            r_top_base <= '0;
                        end else begin
                            r_top      <= r_top + 1'b1;
                            r_top_base <= r_top_base + ADDR_W'(COLUMNS);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out       <= r_pend;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // A finished request goes straight to the output when it is free.
            if (fin_v) begin
                if (out_free) begin
                    r_out       <= fin;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end else begin
                    r_pend  <= fin;
                    r_state <= S_DONE;
                end
            end
        end
    end

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cur_y) < ROWS) && (int'(r_cur_x) < COLUMNS))
        else $error("cursor outside the screen");

    a_top_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top_base == ADDR_W'(r_top) * ADDR_W'(COLUMNS))
        else $error("top row base address out of step with top row");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (o_cursor_row == 6'(ROWS - 1)))
        else $error("scroll result not on the bottom row");

    a_scroll_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> (r_sc_cnt <= CNT_W'(COLUMNS)))
        else $error("scroll counter overran the row");

    a_scroll_moves_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL && r_sc_cnt == CNT_W'(COLUMNS)) |=> (r_top != $past(r_top)))
        else $error("scroll finished without moving the top row");

endmodule
